[design/dct_pkg.sv]
// Shared types, constants and micro-op programs for the 8x8 DCT block.
// Used by dct_ctrl, dct_dpath, the top level and the port checker.
package dct_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int IN_W = 20;
  localparam int ROW_W = 24;
  localparam int TMP_W = 32;
  localparam int ACC_W = TMP_W + COEF_W + 1;
  localparam int TA_W = 5;
  localparam int PC_W = 7;
  localparam int CI_W = 4;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // coefficient indexes
  localparam logic [CI_W-1:0] K_A = 4'd0;
  localparam logic [CI_W-1:0] K_B = 4'd1;
  localparam logic [CI_W-1:0] K_C = 4'd2;
  localparam logic [CI_W-1:0] K_D = 4'd3;
  localparam logic [CI_W-1:0] K_E = 4'd4;
  localparam logic [CI_W-1:0] K_F = 4'd5;
  localparam logic [CI_W-1:0] K_G = 4'd6;
  localparam logic [CI_W-1:0] K_H = 4'd7;
  localparam logic [CI_W-1:0] K_I = 4'd8;
  localparam logic [CI_W-1:0] K_J = 4'd9;
  localparam logic [CI_W-1:0] K_L = 4'd10;
  localparam logic [CI_W-1:0] K_M = 4'd11;
  localparam logic [CI_W-1:0] K_HALF = 4'd12;

  typedef enum logic [2:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_MACR, OP_MULR, OP_ST, OP_END
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [TA_W-1:0] a;
    logic [TA_W-1:0] b;
    logic [TA_W-1:0] d;
    logic [CI_W-1:0] k;
    logic            neg;
  } uinst_t;

  typedef struct packed {
    logic                 load_we;
    logic [5:0]           load_addr;
    logic                 exec;
    uinst_t               inst;
    logic                 col;
    logic [2:0]           line;
    logic                 emit;
    logic [5:0]           emit_addr;
  } cmd_t;

  typedef struct packed {
    logic                   mode;
    logic signed [IN_W-1:0] in_value;
  } in_t;

  typedef struct packed {
    logic signed [IN_W-1:0] out_value;
    logic                   last;
  } out_t;

  // Coefficient in COEF_FRAC_BITS fractional bits, rounded from the Q18 table
  function automatic logic signed [COEF_W-1:0] coef(logic [CI_W-1:0] idx);
    int q;
    int v;
    int sh;
    sh = 18 - COEF_FRAC_BITS;
    unique case (idx)
      K_A:     q = 363604;
      K_B:     q = 72325;
      K_C:     q = 308249;
      K_D:     q = 205965;
      K_E:     q = 92682;
      K_F:     q = 121095;
      K_G:     q = 50159;
      K_H:     q = 185364;
      K_I:     q = 370728;
      K_J:     q = 342508;
      K_L:     q = 141871;
      K_M:     q = 65536;
      default: q = 0;
    endcase
    if (idx == K_HALF) begin
      v = 1 << (COEF_FRAC_BITS - 1);
    end else if (sh == 0) begin
      v = q;
    end else begin
      v = (q + (1 << (sh - 1))) >> sh;
    end
    return COEF_W'(v);
  endfunction

  function automatic uinst_t ui(op_t op, int a, int b, int d, logic [CI_W-1:0] k,
                                logic neg);
    uinst_t u;
    u.op = op;
    u.a = TA_W'(a);
    u.b = TA_W'(b);
    u.d = TA_W'(d);
    u.k = k;
    u.neg = neg;
    return u;
  endfunction

  // Forward 8-point butterfly; temps 0-7 hold the line, 8 and up hold nodes
  function automatic uinst_t fwd_prog(logic [PC_W-1:0] pc);
    uinst_t u;
    unique case (pc)
      7'd0:  u = ui(OP_LD, 0, 0, 0, K_A, 1'b0);
      7'd1:  u = ui(OP_LD, 0, 0, 1, K_A, 1'b0);
      7'd2:  u = ui(OP_LD, 0, 0, 2, K_A, 1'b0);
      7'd3:  u = ui(OP_LD, 0, 0, 3, K_A, 1'b0);
      7'd4:  u = ui(OP_LD, 0, 0, 4, K_A, 1'b0);
      7'd5:  u = ui(OP_LD, 0, 0, 5, K_A, 1'b0);
      7'd6:  u = ui(OP_LD, 0, 0, 6, K_A, 1'b0);
      7'd7:  u = ui(OP_LD, 0, 0, 7, K_A, 1'b0);
      7'd8:  u = ui(OP_ADD, 0, 7, 8, K_A, 1'b0);
      7'd9:  u = ui(OP_ADD, 1, 6, 9, K_A, 1'b0);
      7'd10: u = ui(OP_ADD, 2, 5, 10, K_A, 1'b0);
      7'd11: u = ui(OP_ADD, 3, 4, 11, K_A, 1'b0);
      7'd12: u = ui(OP_SUB, 0, 7, 12, K_A, 1'b0);
      7'd13: u = ui(OP_SUB, 1, 6, 13, K_A, 1'b0);
      7'd14: u = ui(OP_SUB, 2, 5, 14, K_A, 1'b0);
      7'd15: u = ui(OP_SUB, 3, 4, 15, K_A, 1'b0);
      7'd16: u = ui(OP_ADD, 8, 11, 16, K_A, 1'b0);
      7'd17: u = ui(OP_ADD, 9, 10, 17, K_A, 1'b0);
      7'd18: u = ui(OP_SUB, 8, 11, 18, K_A, 1'b0);
      7'd19: u = ui(OP_SUB, 9, 10, 19, K_A, 1'b0);
      7'd20: u = ui(OP_MUL, 12, 0, 0, K_A, 1'b0);
      7'd21: u = ui(OP_MACR, 15, 0, 20, K_B, 1'b0);
      7'd22: u = ui(OP_MUL, 13, 0, 0, K_C, 1'b0);
      7'd23: u = ui(OP_MACR, 14, 0, 21, K_D, 1'b0);
      7'd24: u = ui(OP_MUL, 13, 0, 0, K_D, 1'b1);
      7'd25: u = ui(OP_MACR, 14, 0, 22, K_C, 1'b0);
      7'd26: u = ui(OP_MUL, 12, 0, 0, K_B, 1'b0);
      7'd27: u = ui(OP_MACR, 15, 0, 23, K_A, 1'b1);
      7'd28: u = ui(OP_SUB, 20, 21, 24, K_A, 1'b0);
      7'd29: u = ui(OP_MULR, 24, 0, 25, K_E, 1'b0);
      7'd30: u = ui(OP_SUB, 22, 23, 24, K_A, 1'b0);
      7'd31: u = ui(OP_MULR, 24, 0, 26, K_E, 1'b0);
      7'd32: u = ui(OP_ADD, 16, 17, 24, K_A, 1'b0);
      7'd33: u = ui(OP_MULR, 24, 0, 27, K_E, 1'b0);
      7'd34: u = ui(OP_ST, 27, 0, 0, K_A, 1'b0);
      7'd35: u = ui(OP_ADD, 20, 21, 24, K_A, 1'b0);
      7'd36: u = ui(OP_MULR, 24, 0, 27, K_E, 1'b0);
      7'd37: u = ui(OP_ST, 27, 0, 1, K_A, 1'b0);
      7'd38: u = ui(OP_MUL, 18, 0, 0, K_F, 1'b0);
      7'd39: u = ui(OP_MACR, 19, 0, 27, K_G, 1'b0);
      7'd40: u = ui(OP_ST, 27, 0, 2, K_A, 1'b0);
      7'd41: u = ui(OP_SUB, 25, 26, 24, K_A, 1'b0);
      7'd42: u = ui(OP_MULR, 24, 0, 27, K_H, 1'b0);
      7'd43: u = ui(OP_ST, 27, 0, 3, K_A, 1'b0);
      7'd44: u = ui(OP_SUB, 16, 17, 24, K_A, 1'b0);
      7'd45: u = ui(OP_MULR, 24, 0, 27, K_E, 1'b0);
      7'd46: u = ui(OP_ST, 27, 0, 4, K_A, 1'b0);
      7'd47: u = ui(OP_ADD, 25, 26, 24, K_A, 1'b0);
      7'd48: u = ui(OP_MULR, 24, 0, 27, K_H, 1'b0);
      7'd49: u = ui(OP_ST, 27, 0, 5, K_A, 1'b0);
      7'd50: u = ui(OP_MUL, 18, 0, 0, K_G, 1'b0);
      7'd51: u = ui(OP_MACR, 19, 0, 27, K_F, 1'b1);
      7'd52: u = ui(OP_ST, 27, 0, 6, K_A, 1'b0);
      7'd53: u = ui(OP_ADD, 22, 23, 24, K_A, 1'b0);
      7'd54: u = ui(OP_MULR, 24, 0, 27, K_E, 1'b0);
      7'd55: u = ui(OP_ST, 27, 0, 7, K_A, 1'b0);
      default: u = ui(OP_END, 0, 0, 0, K_A, 1'b0);
    endcase
    return u;
  endfunction

  // Inverse 8-point butterfly
  function automatic uinst_t inv_prog(logic [PC_W-1:0] pc);
    uinst_t u;
    unique case (pc)
      7'd0:  u = ui(OP_LD, 0, 0, 0, K_A, 1'b0);
      7'd1:  u = ui(OP_LD, 0, 0, 1, K_A, 1'b0);
      7'd2:  u = ui(OP_LD, 0, 0, 2, K_A, 1'b0);
      7'd3:  u = ui(OP_LD, 0, 0, 3, K_A, 1'b0);
      7'd4:  u = ui(OP_LD, 0, 0, 4, K_A, 1'b0);
      7'd5:  u = ui(OP_LD, 0, 0, 5, K_A, 1'b0);
      7'd6:  u = ui(OP_LD, 0, 0, 6, K_A, 1'b0);
      7'd7:  u = ui(OP_LD, 0, 0, 7, K_A, 1'b0);
      7'd8:  u = ui(OP_MULR, 0, 0, 8, K_I, 1'b0);
      7'd9:  u = ui(OP_MUL, 1, 0, 0, K_A, 1'b0);
      7'd10: u = ui(OP_MACR, 7, 0, 9, K_B, 1'b0);
      7'd11: u = ui(OP_MUL, 2, 0, 0, K_J, 1'b0);
      7'd12: u = ui(OP_MACR, 6, 0, 10, K_L, 1'b0);
      7'd13: u = ui(OP_MUL, 3, 0, 0, K_C, 1'b0);
      7'd14: u = ui(OP_MACR, 5, 0, 11, K_D, 1'b0);
      7'd15: u = ui(OP_MULR, 4, 0, 12, K_I, 1'b0);
      7'd16: u = ui(OP_MUL, 3, 0, 0, K_D, 1'b1);
      7'd17: u = ui(OP_MACR, 5, 0, 13, K_C, 1'b0);
      7'd18: u = ui(OP_MUL, 2, 0, 0, K_L, 1'b0);
      7'd19: u = ui(OP_MACR, 6, 0, 14, K_J, 1'b1);
      7'd20: u = ui(OP_MUL, 1, 0, 0, K_B, 1'b1);
      7'd21: u = ui(OP_MACR, 7, 0, 15, K_A, 1'b0);
      7'd22: u = ui(OP_ADD, 8, 12, 16, K_A, 1'b0);
      7'd23: u = ui(OP_ADD, 9, 11, 17, K_A, 1'b0);
      7'd24: u = ui(OP_MULR, 10, 0, 18, K_I, 1'b0);
      7'd25: u = ui(OP_SUB, 8, 12, 19, K_A, 1'b0);
      7'd26: u = ui(OP_SUB, 9, 11, 20, K_A, 1'b0);
      7'd27: u = ui(OP_SUB, 16, 18, 30, K_A, 1'b0);
      7'd28: u = ui(OP_MULR, 30, 0, 21, K_E, 1'b0);
      7'd29: u = ui(OP_ADD, 19, 20, 30, K_A, 1'b0);
      7'd30: u = ui(OP_MULR, 30, 0, 22, K_E, 1'b0);
      7'd31: u = ui(OP_SUB, 19, 20, 30, K_A, 1'b0);
      7'd32: u = ui(OP_MULR, 30, 0, 23, K_E, 1'b0);
      7'd33: u = ui(OP_MULR, 14, 0, 24, K_I, 1'b0);
      7'd34: u = ui(OP_ADD, 13, 15, 25, K_A, 1'b0);
      7'd35: u = ui(OP_SUB, 13, 15, 26, K_A, 1'b0);
      7'd36: u = ui(OP_ADD, 24, 25, 30, K_A, 1'b0);
      7'd37: u = ui(OP_MULR, 30, 0, 27, K_E, 1'b0);
      7'd38: u = ui(OP_SUB, 24, 25, 30, K_A, 1'b0);
      7'd39: u = ui(OP_MULR, 30, 0, 28, K_E, 1'b0);
      7'd40: u = ui(OP_MULR, 26, 0, 29, K_HALF, 1'b0);
      7'd41: u = ui(OP_ADD, 16, 18, 31, K_A, 1'b0);
      7'd42: u = ui(OP_MUL, 31, 0, 0, K_M, 1'b0);
      7'd43: u = ui(OP_MACR, 17, 0, 30, K_E, 1'b0);
      7'd44: u = ui(OP_ST, 30, 0, 0, K_A, 1'b0);
      7'd45: u = ui(OP_MUL, 31, 0, 0, K_M, 1'b0);
      7'd46: u = ui(OP_MACR, 17, 0, 30, K_E, 1'b1);
      7'd47: u = ui(OP_ST, 30, 0, 7, K_A, 1'b0);
      7'd48: u = ui(OP_ADD, 22, 28, 30, K_A, 1'b0);
      7'd49: u = ui(OP_MULR, 30, 0, 30, K_H, 1'b0);
      7'd50: u = ui(OP_ST, 30, 0, 1, K_A, 1'b0);
      7'd51: u = ui(OP_SUB, 22, 28, 30, K_A, 1'b0);
      7'd52: u = ui(OP_MULR, 30, 0, 30, K_H, 1'b0);
      7'd53: u = ui(OP_ST, 30, 0, 2, K_A, 1'b0);
      7'd54: u = ui(OP_ADD, 21, 29, 30, K_A, 1'b0);
      7'd55: u = ui(OP_MULR, 30, 0, 30, K_H, 1'b0);
      7'd56: u = ui(OP_ST, 30, 0, 3, K_A, 1'b0);
      7'd57: u = ui(OP_SUB, 21, 29, 30, K_A, 1'b0);
      7'd58: u = ui(OP_MULR, 30, 0, 30, K_H, 1'b0);
      7'd59: u = ui(OP_ST, 30, 0, 4, K_A, 1'b0);
      7'd60: u = ui(OP_SUB, 23, 27, 30, K_A, 1'b0);
      7'd61: u = ui(OP_MULR, 30, 0, 30, K_H, 1'b0);
      7'd62: u = ui(OP_ST, 30, 0, 5, K_A, 1'b0);
      7'd63: u = ui(OP_ADD, 23, 27, 30, K_A, 1'b0);
      7'd64: u = ui(OP_MULR, 30, 0, 30, K_H, 1'b0);
      7'd65: u = ui(OP_ST, 30, 0, 6, K_A, 1'b0);
      default: u = ui(OP_END, 0, 0, 0, K_A, 1'b0);
    endcase
    return u;
  endfunction

endpackage

[design/dct_ctrl.sv]
// Controller for the 8x8 DCT: load, micro-op sequencing over 16 passes, emit.
// Depends on dct_pkg for the command struct and the micro-op programs.
module dct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_last,
  output dct_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_LOAD    = 5'b00001,
    S_RD      = 5'b00010,
    S_EX      = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [5:0]                 load_cnt_r, load_cnt_nxt;
  logic                       dir_r, dir_nxt;
  logic [3:0]                 pass_r, pass_nxt;
  logic [dct_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [5:0]                 emit_cnt_r, emit_cnt_nxt;
  dct_pkg::uinst_t            inst;
  logic                       in_acc;

  assign inst = dir_r ? dct_pkg::inv_prog(pc_r) : dct_pkg::fwd_prog(pc_r);
  assign in_stall = (state_r != S_LOAD);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state_r == S_EMIT);
  assign out_last = (emit_cnt_r == 6'd63);

  // drive datapath commands
  always_comb begin
    cmd.load_we = in_acc;
    cmd.load_addr = load_cnt_r;
    cmd.exec = (state_r == S_EX);
    cmd.inst = inst;
    cmd.col = pass_r[3];
    cmd.line = pass_r[2:0];
    cmd.emit = (state_r == S_EMIT_RD) || (state_r == S_EMIT);
    cmd.emit_addr = emit_cnt_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    load_cnt_nxt = load_cnt_r;
    dir_nxt = dir_r;
    pass_nxt = pass_r;
    pc_nxt = pc_r;
    emit_cnt_nxt = emit_cnt_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (load_cnt_r == 6'd0) begin
            dir_nxt = in_mode;
          end
          load_cnt_nxt = load_cnt_r + 6'd1;
          if (load_cnt_r == 6'd63) begin
            state_nxt = S_RD;
            pass_nxt = 4'd0;
            pc_nxt = '0;
          end
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        if (inst.op == dct_pkg::OP_END) begin
          pc_nxt = '0;
          if (pass_r == 4'd15) begin
            emit_cnt_nxt = 6'd0;
            state_nxt = S_EMIT_RD;
          end else begin
            pass_nxt = pass_r + 4'd1;
            state_nxt = S_RD;
          end
        end else begin
          pc_nxt = pc_r + dct_pkg::PC_W'(1);
          state_nxt = S_RD;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_stall) begin
          if (emit_cnt_r == 6'd63) begin
            state_nxt = S_LOAD;
          end else begin
            emit_cnt_nxt = emit_cnt_r + 6'd1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      load_cnt_r <= '0;
      dir_r <= 1'b0;
      pass_r <= '0;
      pc_r <= '0;
      emit_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      dir_r <= dir_nxt;
      pass_r <= pass_nxt;
      pc_r <= pc_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

endmodule

[design/dct_dpath.sv]
// Datapath for the 8x8 DCT: block and row-pass memories, temp file, one MAC.
// Depends on dct_pkg for widths, coefficients and the command struct.
module dct_dpath (
  input  logic                            clk,
  input  dct_pkg::cmd_t                   cmd,
  input  logic signed [dct_pkg::IN_W-1:0] in_value,
  output logic signed [dct_pkg::IN_W-1:0] out_value
);

  localparam int TMP_W = dct_pkg::TMP_W;
  localparam int ACC_W = dct_pkg::ACC_W;
  localparam int IN_W = dct_pkg::IN_W;
  localparam int ROW_W = dct_pkg::ROW_W;
  localparam logic signed [TMP_W-1:0] ROW_MAX = TMP_W'((64'sd1 <<< (ROW_W - 1)) - 1);
  localparam logic signed [TMP_W-1:0] ROW_MIN = ~ROW_MAX;
  localparam logic signed [TMP_W-1:0] OUT_MAX = TMP_W'((64'sd1 <<< (IN_W - 1)) - 1);
  localparam logic signed [TMP_W-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [IN_W-1:0]   bs_mem [64];
  logic signed [ROW_W-1:0]  rs_mem [64];
  logic signed [TMP_W-1:0]  tf_mem [32];

  logic signed [IN_W-1:0]   bs_rdata_r;
  logic signed [ROW_W-1:0]  rs_rdata_r;
  logic signed [TMP_W-1:0]  ra_r, rb_r;
  logic signed [ACC_W-1:0]  acc_r;

  dct_pkg::uinst_t                       inst;
  logic [2:0]                            elem;
  logic [5:0]                            bs_raddr;
  logic signed [dct_pkg::COEF_W-1:0]     kval;
  logic signed [TMP_W+dct_pkg::COEF_W-1:0] mprod;
  logic signed [ACC_W-1:0]               prod;
  logic signed [ACC_W-1:0]               sum;
  logic signed [ACC_W-1:0]               shifted;
  logic signed [TMP_W-1:0]               rnd_val;
  logic signed [ROW_W-1:0]               st_row;
  logic signed [IN_W-1:0]                st_out;

  assign inst = cmd.inst;
  assign elem = inst.d[2:0];
  assign bs_raddr = cmd.emit ? cmd.emit_addr : {cmd.line, elem};
  assign out_value = bs_rdata_r;

  // multiply, then one add folds in the accumulator or the rounding half
  always_comb begin
    kval = dct_pkg::coef(inst.k);
    mprod = kval * ra_r;
    prod = inst.neg ? -ACC_W'(mprod) : ACC_W'(mprod);
    sum = ((inst.op == dct_pkg::OP_MACR) ? acc_r : dct_pkg::RND_HALF) + prod;
    shifted = sum >>> dct_pkg::COEF_FRAC_BITS;
    rnd_val = TMP_W'(shifted);
  end

  // saturate store values
  always_comb begin
    if (ra_r > ROW_MAX) begin
      st_row = ROW_MAX[ROW_W-1:0];
    end else if (ra_r < ROW_MIN) begin
      st_row = ROW_MIN[ROW_W-1:0];
    end else begin
      st_row = ra_r[ROW_W-1:0];
    end
    if (ra_r > OUT_MAX) begin
      st_out = OUT_MAX[IN_W-1:0];
    end else if (ra_r < OUT_MIN) begin
      st_out = OUT_MIN[IN_W-1:0];
    end else begin
      st_out = ra_r[IN_W-1:0];
    end
  end

  // block store: input load, column results, emission read
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      bs_mem[cmd.load_addr] <= in_value;
    end else if (cmd.exec && inst.op == dct_pkg::OP_ST && cmd.col) begin
      bs_mem[{elem, cmd.line}] <= st_out;
    end
    bs_rdata_r <= bs_mem[bs_raddr];
  end

  // row-pass store: written by row passes, read down columns
  always_ff @(posedge clk) begin
    if (cmd.exec && inst.op == dct_pkg::OP_ST && !cmd.col) begin
      rs_mem[{cmd.line, elem}] <= st_row;
    end
    rs_rdata_r <= rs_mem[{elem, cmd.line}];
  end

  // temp file: two registered reads, at most one write per executed micro-op
  always_ff @(posedge clk) begin
    ra_r <= tf_mem[inst.a];
    rb_r <= tf_mem[inst.b];
    if (cmd.exec) begin
      unique case (inst.op)
        dct_pkg::OP_LD: begin
          tf_mem[inst.d] <= cmd.col ? TMP_W'(rs_rdata_r) : TMP_W'(bs_rdata_r);
        end
        dct_pkg::OP_ADD:  tf_mem[inst.d] <= ra_r + rb_r;
        dct_pkg::OP_SUB:  tf_mem[inst.d] <= ra_r - rb_r;
        dct_pkg::OP_MUL:  acc_r <= sum;
        dct_pkg::OP_MACR: tf_mem[inst.d] <= rnd_val;
        dct_pkg::OP_MULR: tf_mem[inst.d] <= rnd_val;
        dct_pkg::OP_ST, dct_pkg::OP_END: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/dct_8x8_forward_inverse.sv]
// Top level of the separable 8x8 forward/inverse DCT.
// Depends on dct_pkg, dct_ctrl and dct_dpath.
//
// The block takes 64 values of one 8x8 block in row-major order, one per cycle
// while in_stall is low; the first value's mode picks forward (0) or inverse
// (1). After the 64th value the block runs eight row passes and eight column
// passes on one shared multiply-accumulate unit, stepping a fixed micro-op
// sequence with a read state and an execute state per micro-op: 57 micro-ops
// a pass forward, 67 inverse. It then emits the 64 results in row-major order,
// each through a read state and an emit state, with last on the 64th, and
// takes no input until the last result is taken. Its speed is set by the
// single multiplier and the temp-file port.
module dct_8x8_forward_inverse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dct_pkg::out_t out_data
);

  dct_pkg::cmd_t cmd;
  logic          out_last;
  logic signed [dct_pkg::IN_W-1:0] out_value;

  dct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (out_last),
    .cmd       (cmd)
  );

  dct_dpath u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .in_value  (in_data.in_value),
    .out_value (out_value)
  );

  // pack the result request
  always_comb begin
    out_data.out_value = out_value;
    out_data.last = out_last;
  end

endmodule

[design/dct_chk.sv]
// Port checker for the 8x8 DCT top level, attached by bind.
// Depends on dct_pkg for the channel struct types.
module dct_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input dct_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input dct_pkg::out_t out_data
);

  // hold a stalled input request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input request changed");

  // hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no input taken while results are pending
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during emission");

  // drop valid after the last result of a block
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid && !in_stall)
    else $error("block did not end after last");

endmodule

bind dct_8x8_forward_inverse dct_chk u_chk (.*);

[tb/dct_8x8_forward_inverse_test.sv]
// Testbench for the 8x8 forward/inverse DCT: feeds blocks of 64 values with
// random bursts and output stalls, predicts every result, and compares.
// Depends on dct_pkg and the dct_8x8_forward_inverse top level.
module dct_8x8_forward_inverse_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CF = 14;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dct_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dct_pkg::out_t out_data;

  dct_8x8_forward_inverse i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  dct_pkg::in_t pending_requests[$];
  dct_pkg::out_t expected_results[$];
  longint pixel_buf[64];
  int load_idx = 0;
  logic block_inverse = 1'b0;
  int errors = 0;
  int blocks_sent = 0;
  int results_seen = 0;
  longint cycles = 0;

  // Coefficients rounded from the Q18 table
  function automatic longint kq(int q);
    return (longint'(q) + 8) >>> 4;
  endfunction

  function automatic longint rnd(longint acc);
    return (acc + (longint'(1) << (CF - 1))) >>> CF;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  // One 8-point butterfly, forward or inverse
  function automatic void butterfly(input logic inv, input longint s[8],
                                    output longint d[8]);
    longint ka, kb, kc, kd, ke, kf, kg, kh, ki, kj, kl, km;
    longint a0, a1, a2, a3, b0, b1, b2, b3, e0, e1, e2, e3, p, q, r, t, u, w;
    longint y0, y1, y2, y3, y4, y5, y6, y7, g0, g1, g2, g3, g4;
    longint m0, m1, m2, n0, n1, n2, n3, n4, n5;
    ka = kq(363604); kb = kq(72325); kc = kq(308249); kd = kq(205965);
    ke = kq(92682); kf = kq(121095); kg = kq(50159); kh = kq(185364);
    ki = kq(370728); kj = kq(342508); kl = kq(141871); km = kq(65536);
    if (!inv) begin
      a0 = s[0] + s[7]; a1 = s[1] + s[6]; a2 = s[2] + s[5]; a3 = s[3] + s[4];
      b0 = s[0] - s[7]; b1 = s[1] - s[6]; b2 = s[2] - s[5]; b3 = s[3] - s[4];
      e0 = a0 + a3; e1 = a1 + a2; e2 = a0 - a3; e3 = a1 - a2;
      p = rnd(ka * b0 + kb * b3);
      q = rnd(kc * b1 + kd * b2);
      r = rnd(-kd * b1 + kc * b2);
      t = rnd(kb * b0 - ka * b3);
      u = rnd(ke * (p - q));
      w = rnd(ke * (r - t));
      d[0] = rnd(ke * (e0 + e1));
      d[1] = rnd(ke * (p + q));
      d[2] = rnd(kf * e2 + kg * e3);
      d[3] = rnd(kh * (u - w));
      d[4] = rnd(ke * (e0 - e1));
      d[5] = rnd(kh * (u + w));
      d[6] = rnd(kg * e2 - kf * e3);
      d[7] = rnd(ke * (r + t));
    end else begin
      y0 = rnd(ki * s[0]);
      y1 = rnd(ka * s[1] + kb * s[7]);
      y2 = rnd(kj * s[2] + kl * s[6]);
      y3 = rnd(kc * s[3] + kd * s[5]);
      y4 = rnd(ki * s[4]);
      y5 = rnd(-kd * s[3] + kc * s[5]);
      y6 = rnd(kl * s[2] - kj * s[6]);
      y7 = rnd(-kb * s[1] + ka * s[7]);
      g0 = y0 + y4; g1 = y1 + y3; g2 = rnd(ki * y2);
      g3 = y0 - y4; g4 = y1 - y3;
      m0 = rnd(ke * (g0 - g2));
      m1 = rnd(ke * (g3 + g4));
      m2 = rnd(ke * (g3 - g4));
      n0 = rnd(ki * y6);
      n1 = y5 + y7; n2 = y5 - y7;
      n3 = rnd(ke * (n0 + n1));
      n4 = rnd(ke * (n0 - n1));
      n5 = rnd((longint'(1) << (CF - 1)) * n2);
      d[0] = rnd(km * (g0 + g2) + ke * g1);
      d[1] = rnd(kh * (m1 + n4));
      d[2] = rnd(kh * (m1 - n4));
      d[3] = rnd(kh * (m0 + n5));
      d[4] = rnd(kh * (m0 - n5));
      d[5] = rnd(kh * (m2 - n3));
      d[6] = rnd(kh * (m2 + n3));
      d[7] = rnd(km * (g0 + g2) - ke * g1);
    end
  endfunction

  // Take one accepted request; on the 64th push the whole transformed block
  task automatic transform_request(dct_pkg::in_t req);
    longint rows[64];
    longint s[8];
    longint d[8];
    dct_pkg::out_t o;
    if (load_idx == 0) block_inverse = req.mode;
    pixel_buf[load_idx] = longint'(req.in_value);
    load_idx = (load_idx + 1) % 64;
    if (load_idx != 0) return;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) s[c] = pixel_buf[r * 8 + c];
      butterfly(block_inverse, s, d);
      for (int c = 0; c < 8; c++) rows[r * 8 + c] = clip(d[c], 24);
    end
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) s[r] = rows[r * 8 + c];
      butterfly(block_inverse, s, d);
      for (int r = 0; r < 8; r++) rows[r * 8 + c] = clip(d[r], 20);
    end
    for (int k = 0; k < 64; k++) begin
      o.out_value = dct_pkg::IN_W'(rows[k]);
      o.last = (k == 63);
      expected_results.push_back(o);
    end
    blocks_sent++;
  endtask

  // Queue one block; kind picks the value pattern
  task automatic queue_block(logic mode, int kind);
    dct_pkg::in_t req;
    for (int k = 0; k < 64; k++) begin
      req.mode = (k == 0) ? mode : 1'($urandom);
      case (kind)
        0: req.in_value = 20'sh7FFFF;
        1: req.in_value = -20'sh80000;
        2: req.in_value = (k % 2) ? 20'sh7FFFF : -20'sh80000;
        3: req.in_value = 20'($urandom);
        4: req.in_value = 20'($signed($urandom_range(0, 8191)) - 4096);
        default: req.in_value = (k == 0) ? 20'sh00100 : '0;
      endcase
      pending_requests.push_back(req);
    end
  endtask

  // Driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) transform_request(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: own stall pattern, compare each result with the oldest expectation
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result out_value=%0d last=%0b",
                 out_data.out_value, out_data.last);
          errors++;
        end else begin
          dct_pkg::out_t e;
          e = expected_results.pop_front();
          if (out_data.out_value !== e.out_value) begin
            $error("out_value expected %0d actual %0d", e.out_value, out_data.out_value);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $error("last expected %0b actual %0b", e.last, out_data.last);
            errors++;
          end
        end
      end
      if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= (cycles % 7) < 3;
      endcase
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("dct_8x8_forward_inverse_test NOT OK");
      $finish;
    end
  end

  initial begin
    // directed: extremes, both directions, impulse, mode change mid-block
    queue_block(1'b0, 0);
    queue_block(1'b1, 1);
    queue_block(1'b0, 2);
    queue_block(1'b1, 5);
    // random blocks, mostly moderate values, some full range
    for (int b = 0; b < 3; b++)
      queue_block(1'($urandom), ($urandom_range(0, 2) == 0) ? 3 : 4);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_requests.size() == 0 && !in_valid && blocks_sent == 7 &&
          expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("Covered %0d blocks in both directions, %0d results checked.",
             blocks_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("dct_8x8_forward_inverse_test OK");
    else
      $display("dct_8x8_forward_inverse_test NOT OK");
    $finish;
  end
endmodule
